@@ hdl/tile_line_address_walker_defines.svh @@
// ---------------------------------------------------------------------------
// Tile line address walker: assertion macros
// Clocked property checks, compiled out when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef TILE_LINE_ADDRESS_WALKER_DEFINES_SVH
`define TILE_LINE_ADDRESS_WALKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define TLAW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tlaw assertion failed");

// expr must never be true outside reset
`define TLAW_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("tlaw forbidden condition seen");

`else

`define TLAW_ASSERT(label, clk, rst, prop)
`define TLAW_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

@@ hdl/tlaw_pkg.sv @@
// ---------------------------------------------------------------------------
// Tile line address walker package
// Field widths, register indexes, shared structs.
// ---------------------------------------------------------------------------
`default_nettype none

package tlaw_pkg;

   localparam int ADDR_W         = 32;
   localparam int STRIDE_W       = 16;
   localparam int DIM_W          = 13;
   localparam int IDX_W          = 12;
   localparam int PITCH_W        = 16;
   localparam int LINEAR_W       = IDX_W + PITCH_W;
   localparam int LINE_INDEX_W   = 26;
   localparam int LINE_SHIFT_DEFAULT = 6;
   localparam int MAX_DIM        = 4096;
   localparam int QUEUE_DEPTH    = 2;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = ADDR_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_ADDRESS  = 3'd0,
      CSR_ELEMENT_STRIDE = 3'd1,
      CSR_TILE_ROWS      = 3'd2,
      CSR_TILE_COLS      = 3'd3,
      CSR_ROW_PITCH      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   start_address;
      logic [STRIDE_W-1:0] element_stride;
      logic [DIM_W-1:0]    tile_rows;
      logic [DIM_W-1:0]    tile_cols;
      logic [PITCH_W-1:0]  row_pitch;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      start_address:  '0,
      element_stride: STRIDE_W'(1),
      tile_rows:      DIM_W'(1),
      tile_cols:      DIM_W'(1),
      row_pitch:      PITCH_W'(1)
   };

   // one classified element handed from front to back
   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             fresh;   // first element of a tile: no line remembered
      logic             done;    // last element of the tile
   } walk_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

@@ hdl/tile_line_address_walker.sv @@
// ---------------------------------------------------------------------------
// Tile line address walker
// Row-major 2D tile walk producing 64-byte line indexes with coalescing.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_restart
//   rsp      out        rsp_valid / rsp_stall  rsp_emit, rsp_line_index,
//                                              rsp_tile_done
//   csr      in         csr_write_enable       csr_index, csr_write_data
//
// One transaction per cycle sustained while rsp_stall is low; each result passes
// through the queue slot, the offset multiply register, the stride multiply
// register and the start add plus line compare into the result register.
// Throughput is set by the single in-order address pipeline in the back end.
// Synchronous active-high reset clears the walk to element (0,0), empties the
// queue and loads register defaults; there is no clearing pass.
// rsp_stall freezes the whole back pipeline while a result is held; the front
// keeps accepting until the two-entry queue is full, then raises req_stall.
// ---------------------------------------------------------------------------
`default_nettype none

module tile_line_address_walker #(
   parameter int LINE_SHIFT = tlaw_pkg::LINE_SHIFT_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_restart,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_emit,
   output logic [tlaw_pkg::LINE_INDEX_W-1:0]  rsp_line_index,
   output logic                               rsp_tile_done,
   // register write port
   input  wire logic                          csr_write_enable,
   input  wire logic [tlaw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tlaw_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import tlaw_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   walk_item_type    push_item, pop_item;
   logic             push, pop;

   // register file; writes land at once, software must only write while idle; the block does not enforce it
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_START_ADDRESS:  cfg_in.start_address  = csr_write_data[ADDR_W-1:0];
            CSR_ELEMENT_STRIDE: cfg_in.element_stride = csr_write_data[STRIDE_W-1:0];
            CSR_TILE_ROWS:      cfg_in.tile_rows      = csr_write_data[DIM_W-1:0];
            CSR_TILE_COLS:      cfg_in.tile_cols      = csr_write_data[DIM_W-1:0];
            CSR_ROW_PITCH:      cfg_in.row_pitch      = csr_write_data[PITCH_W-1:0];
            default:            cfg_in = cfg_ff;    // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: walk counters, restart handling, last-element tagging
   tlaw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .q_status    (q_status),
      .req_stall   (req_stall),
      .push        (push),
      .push_item   (push_item)
   );

   // decouples the walk from result backpressure
   tlaw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_status  (q_status)
   );

   // back: address math, line compare against last reported line
   tlaw_back #(
      .LINE_SHIFT (LINE_SHIFT)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_status       (q_status),
      .pop_item       (pop_item),
      .pop            (pop),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_emit       (rsp_emit),
      .rsp_line_index (rsp_line_index),
      .rsp_tile_done  (rsp_tile_done)
   );

endmodule

`default_nettype wire

@@ hdl/tlaw_front.sv @@
// ---------------------------------------------------------------------------
// Tile line address walker: front end
// Accepts transactions, steps the row/column walk and tags each element.
// ---------------------------------------------------------------------------
`default_nettype none

module tlaw_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire tlaw_pkg::cfg_type         cfg,
   input  wire logic                      req_valid,
   input  wire logic                      req_restart,
   input  wire tlaw_pkg::queue_status_type q_status,
   output logic                           req_stall,
   output logic                           push,
   output tlaw_pkg::walk_item_type        push_item
);
   import tlaw_pkg::*;

   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic             fresh_ff, fresh_in;
   logic [DIM_W-1:0] rows, cols;
   logic [IDX_W-1:0] cur_row, cur_col;
   logic             last_col, last_row;

   // zero acts as one, above the maximum acts as the maximum
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      return r;
   endfunction

   always_comb begin
      rows      = clamp_dim(cfg.tile_rows);
      cols      = clamp_dim(cfg.tile_cols);
      req_stall = q_status.full;
      push      = req_valid && !q_status.full;
      cur_row   = req_restart ? '0 : row_ff;
      cur_col   = req_restart ? '0 : col_ff;
      last_col  = ({1'b0, cur_col} + DIM_W'(1)) >= cols;
      last_row  = ({1'b0, cur_row} + DIM_W'(1)) >= rows;

      push_item.row   = cur_row;
      push_item.col   = cur_col;
      push_item.fresh = req_restart || fresh_ff;
      push_item.done  = last_col && last_row;

      row_in   = row_ff;
      col_in   = col_ff;
      fresh_in = fresh_ff;
      if (push) begin
         fresh_in = push_item.done;
         if (push_item.done) begin
            row_in = '0;
            col_in = '0;
         end else if (last_col) begin
            row_in = cur_row + IDX_W'(1);
            col_in = '0;
         end else begin
            row_in = cur_row;
            col_in = cur_col + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         fresh_ff <= 1'b1;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         fresh_ff <= fresh_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/tlaw_queue.sv @@
// ---------------------------------------------------------------------------
// Tile line address walker: element queue
// Short FIFO of classified elements between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tile_line_address_walker_defines.svh"

module tlaw_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire tlaw_pkg::walk_item_type push_item,
   input  wire logic                    pop,
   output tlaw_pkg::walk_item_type      pop_item,
   output tlaw_pkg::queue_status_type   q_status
);
   import tlaw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   walk_item_type    item_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      q_status.full  = count_ff == CNT_W'(QUEUE_DEPTH);
      q_status.empty = count_ff == '0;
      pop_item       = item_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) item_ff[wr_ptr_ff] <= push_item;
   end

   `TLAW_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(QUEUE_DEPTH))
   `TLAW_ASSERT_NEVER(a_no_overflow, clock, reset, push && q_status.full)
   `TLAW_ASSERT_NEVER(a_no_underflow, clock, reset, pop && q_status.empty)

endmodule

`default_nettype wire

@@ hdl/tlaw_back.sv @@
// ---------------------------------------------------------------------------
// Tile line address walker: back end
// Address pipeline, line compare and result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tile_line_address_walker_defines.svh"

module tlaw_back #(
   parameter int LINE_SHIFT = tlaw_pkg::LINE_SHIFT_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire tlaw_pkg::cfg_type          cfg,
   input  wire tlaw_pkg::queue_status_type q_status,
   input  wire tlaw_pkg::walk_item_type    pop_item,
   output logic                            pop,
   input  wire logic                       rsp_stall,
   output logic                            rsp_valid,
   output logic                            rsp_emit,
   output logic [tlaw_pkg::LINE_INDEX_W-1:0] rsp_line_index,
   output logic                            rsp_tile_done
);
   import tlaw_pkg::*;

   localparam int LINE_W = ADDR_W - LINE_SHIFT;

   logic                      advance;

   // stage 1: linear element offset
   logic                      v1_ff;
   logic [LINEAR_W-1:0]       lin_ff, lin_in;
   logic                      fresh1_ff, done1_ff;
   logic [LINEAR_W-1:0]       row_part;

   // stage 2: byte offset
   logic                      v2_ff;
   logic [ADDR_W-1:0]         offs_ff, offs_in;
   logic                      fresh2_ff, done2_ff;

   // result stage
   logic                      rsp_valid_ff;
   logic                      emit_ff, emit_in;
   logic [LINE_INDEX_W-1:0]   line_index_ff, line_index_in;
   logic                      done_ff;
   logic [LINE_W-1:0]         prev_line_ff;
   logic [ADDR_W-1:0]         addr;
   logic [ADDR_W-1:0]         addr_shifted;
   logic [LINE_W-1:0]         line_full;

   always_comb begin
      advance  = !rsp_valid_ff || !rsp_stall;
      pop      = advance && !q_status.empty;

      row_part = LINEAR_W'(pop_item.row) * LINEAR_W'(cfg.row_pitch);
      lin_in   = row_part + LINEAR_W'(pop_item.col);

      // only the low address bits matter, the byte address wraps at 32 bits
      offs_in   = ADDR_W'(lin_ff) * ADDR_W'(cfg.element_stride);

      addr          = cfg.start_address + offs_ff;
      addr_shifted  = addr >> LINE_SHIFT;
      line_full     = addr[ADDR_W-1:LINE_SHIFT];
      line_index_in = addr_shifted[LINE_INDEX_W-1:0];
      emit_in       = fresh2_ff || (line_full != prev_line_ff);

      rsp_valid      = rsp_valid_ff;
      rsp_emit       = emit_ff;
      rsp_line_index = line_index_ff;
      rsp_tile_done  = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= pop;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lin_ff        <= lin_in;
         fresh1_ff     <= pop_item.fresh;
         done1_ff      <= pop_item.done;
         offs_ff       <= offs_in;
         fresh2_ff     <= fresh1_ff;
         done2_ff      <= done1_ff;
         emit_ff       <= emit_in;
         line_index_ff <= line_index_in;
         done_ff       <= done2_ff;
      end
      if (advance && v2_ff && emit_in) begin
         prev_line_ff <= line_full;
      end
   end

   `TLAW_ASSERT(a_fresh_emits, clock, reset, (advance && v2_ff && fresh2_ff) |=> rsp_emit)
   `TLAW_ASSERT(a_stage_holds, clock, reset, (v2_ff && !advance) |=> v2_ff)
   `TLAW_ASSERT(a_result_lands, clock, reset, (advance && v2_ff) |=> rsp_valid_ff)

endmodule

`default_nettype wire

@@ verif/tile_line_address_walker_checker.sv @@
// ---------------------------------------------------------------------------
// Tile line address walker checker
// Watches the request, result and register ports. It keeps its own copy of
// the walk position and the register values, predicts each result in order,
// and compares every accepted result with the oldest prediction.
// ---------------------------------------------------------------------------

module tile_line_address_walker_checker
   import tlaw_pkg::*;
#(
   parameter int LINE_SHIFT = LINE_SHIFT_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic                    req_restart,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic                    rsp_emit,
   input  logic [LINE_INDEX_W-1:0] rsp_line_index,
   input  logic                    rsp_tile_done,
   input  logic                    csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data,
   output int                      mismatch_count,
   output int                      pending_count,
   output int                      result_count,
   output int                      tile_count,
   output int                      line_count
);

   localparam int EXPECT_DEPTH = 64;   // far above what the block can hold

   typedef struct packed {
      logic                    emit;
      logic [LINE_INDEX_W-1:0] line_index;
      logic                    tile_done;
   } line_result_type;

   cfg_type           tile_cfg;
   logic [IDX_W-1:0]  walk_row;
   logic [IDX_W-1:0]  walk_col;
   logic [ADDR_W-1:0] last_line;
   logic              have_line;
   line_result_type   expected_lines[EXPECT_DEPTH];
   int                head_slot;
   int                tail_slot;

   // dimension as the walk sees it: zero acts as one, oversize saturates
   function automatic int unsigned effective_dim(logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   // one element of the row-major walk; advances the walk position
   function automatic line_result_type walk_element(logic restart);
      int unsigned       rows;
      int unsigned       cols;
      logic [63:0]       linear;
      logic [63:0]       byte_sum;
      logic [ADDR_W-1:0] line_addr;
      logic              last_col;
      logic              last_row;
      line_result_type   res;
      rows = effective_dim(tile_cfg.tile_rows);
      cols = effective_dim(tile_cfg.tile_cols);
      if (restart) begin
         walk_row  = '0;
         walk_col  = '0;
         have_line = 1'b0;
      end
      linear    = 64'(walk_row) * 64'(tile_cfg.row_pitch) + 64'(walk_col);
      byte_sum  = 64'(tile_cfg.start_address) + 64'(tile_cfg.element_stride) * linear;
      line_addr = byte_sum[ADDR_W-1:0] >> LINE_SHIFT;
      // compare on the whole aligned address, not just the reported bits
      res.emit = !have_line || (line_addr != last_line);
      if (res.emit) begin
         last_line = line_addr;
         have_line = 1'b1;
      end
      res.line_index = line_addr[LINE_INDEX_W-1:0];
      last_col = (32'(walk_col) + 1) >= cols;
      last_row = (32'(walk_row) + 1) >= rows;
      res.tile_done = last_col && last_row;
      if (res.tile_done) begin
         walk_row  = '0;
         walk_col  = '0;
         have_line = 1'b0;
      end else if (last_col) begin
         walk_col = '0;
         walk_row = walk_row + 1'b1;
      end else begin
         walk_col = walk_col + 1'b1;
      end
      return res;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : track
      line_result_type want;
      line_result_type next_line;
      if (reset) begin
         tile_cfg  = CFG_RESET;
         walk_row  = '0;
         walk_col  = '0;
         last_line = '0;
         have_line = 1'b0;
         head_slot = 0;
         tail_slot = 0;
         pending_count  = 0;
         mismatch_count = 0;
         result_count   = 0;
         tile_count     = 0;
         line_count     = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_START_ADDRESS:  tile_cfg.start_address  = csr_write_data[ADDR_W-1:0];
               CSR_ELEMENT_STRIDE: tile_cfg.element_stride = csr_write_data[STRIDE_W-1:0];
               CSR_TILE_ROWS:      tile_cfg.tile_rows      = csr_write_data[DIM_W-1:0];
               CSR_TILE_COLS:      tile_cfg.tile_cols      = csr_write_data[DIM_W-1:0];
               CSR_ROW_PITCH:      tile_cfg.row_pitch      = csr_write_data[PITCH_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            next_line = walk_element(req_restart);
            if (pending_count == EXPECT_DEPTH) begin
               mismatch_count++;
               $display("%0t: outstanding results, expected at most %0d, got %0d",
                        $time, EXPECT_DEPTH, pending_count + 1);
            end else begin
               expected_lines[tail_slot] = next_line;
               tail_slot = (tail_slot + 1) % EXPECT_DEPTH;
               pending_count++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (pending_count == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none, got emit %b line %h done %b",
                        $time, rsp_emit, rsp_line_index, rsp_tile_done);
            end else begin
               want = expected_lines[head_slot];
               head_slot = (head_slot + 1) % EXPECT_DEPTH;
               pending_count--;
               check_field("emit", 32'(want.emit), 32'(rsp_emit));
               check_field("line_index", 32'(want.line_index), 32'(rsp_line_index));
               check_field("tile_done", 32'(want.tile_done), 32'(rsp_tile_done));
               if (want.tile_done) tile_count++;
               if (want.emit) line_count++;
            end
         end
      end
   end

endmodule

@@ verif/tile_line_address_walker_tb.sv @@
// ---------------------------------------------------------------------------
// Tile line address walker testbench
// Drives walk transactions and register setups into the block, with random
// gaps on the request side and random stalls on the result side. A checker
// beside the block predicts and compares every result; this module makes
// stimulus, runs the watchdog and reports the verdict.
// ---------------------------------------------------------------------------

module tile_line_address_walker_tb;
   import tlaw_pkg::*;

   localparam int IDLE_LIMIT      = 1000;  // cycles with no transaction at all
   localparam int RANDOM_SETUPS   = 6;
   localparam int ITEMS_PER_SETUP = 100;
   localparam int RESTART_PCT     = 4;     // restarts are noise in the random part
   localparam int TAIL_CYCLES     = 8;     // extra wait after the last result has come back
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNMAPPED = CSR_INDEX_W'(CSR_ROW_PITCH + 1);
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_UNMAPPED  = '1;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_restart = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_emit;
   logic [LINE_INDEX_W-1:0] rsp_line_index;
   logic                    rsp_tile_done;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_write_data = '0;

   // idle percentages of the two sides; changed by NBA so that the
   // receiver process never sees a change within the same step
   int tx_idle_pct = 19;
   int rx_idle_pct = 75;

   int sent_count  = 0;
   int setup_count = 0;
   int idle_cycles = 0;

   int mismatch_count;
   int pending_count;
   int result_count;
   int tile_count;
   int line_count;

   initial begin
      forever #10 clock = ~clock;
   end

   tile_line_address_walker u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_emit         (rsp_emit),
      .rsp_line_index   (rsp_line_index),
      .rsp_tile_done    (rsp_tile_done),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   tile_line_address_walker_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_emit         (rsp_emit),
      .rsp_line_index   (rsp_line_index),
      .rsp_tile_done    (rsp_tile_done),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count),
      .result_count     (result_count),
      .tile_count       (tile_count),
      .line_count       (line_count)
   );

   // result side: stall at random, decided once per cycle on the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
   end

   // watchdog: any accepted transaction on either channel resets the count
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog, no transaction for %0d cycles, %0d results outstanding",
                  $time, idle_cycles, pending_count);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // One walk transaction. Called on a falling edge, returns on a falling
   // edge. Valid stays up while stalled and the payload is held.
   task automatic send_request(input logic restart);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid   <= 1'b0;
         req_restart <= 1'($urandom);   // junk payload while idle
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      sent_count++;
      @(negedge clock);
   endtask

   // sender goes quiet until every predicted result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   // Program every register, upper data bits filled with junk, then one
   // write to an unmapped index. Only called with the block idle.
   task automatic load_setup(input logic [ADDR_W-1:0]   start,
                             input logic [STRIDE_W-1:0] stride,
                             input logic [DIM_W-1:0]    rows,
                             input logic [DIM_W-1:0]    cols,
                             input logic [PITCH_W-1:0]  pitch);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_START_ADDRESS;
      csr_write_data   <= start;
      @(negedge clock);
      csr_index      <= CSR_ELEMENT_STRIDE;
      csr_write_data <= {16'($urandom), stride};
      @(negedge clock);
      csr_index      <= CSR_TILE_ROWS;
      csr_write_data <= {19'($urandom), rows};
      @(negedge clock);
      csr_index      <= CSR_TILE_COLS;
      csr_write_data <= {19'($urandom), cols};
      @(negedge clock);
      csr_index      <= CSR_ROW_PITCH;
      csr_write_data <= {16'($urandom), pitch};
      @(negedge clock);
      csr_index      <= CSR_INDEX_W'($urandom_range(CSR_FIRST_UNMAPPED, CSR_LAST_UNMAPPED));
      csr_write_data <= $urandom;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      setup_count++;
   endtask

   // tile dimension: mostly small so tiles complete often, with zero,
   // the maximum and out-of-range values mixed in
   function automatic logic [DIM_W-1:0] random_dim();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return DIM_W'(MAX_DIM);
         2:       return DIM_W'($urandom);
         3, 4:    return DIM_W'($urandom_range(7, 40));
         default: return DIM_W'($urandom_range(1, 6));
      endcase
   endfunction

   task automatic random_setup();
      logic [ADDR_W-1:0]   start;
      logic [STRIDE_W-1:0] stride;
      logic [DIM_W-1:0]    rows;
      logic [DIM_W-1:0]    cols;
      logic [PITCH_W-1:0]  pitch;
      case ($urandom_range(0, 3))
         0:       start = '0;
         1:       start = '1 - $urandom_range(0, 511);   // walks wrap past the top
         default: start = $urandom;
      endcase
      rows = random_dim();
      cols = random_dim();
      case ($urandom_range(0, 5))
         0:       stride = '0;
         1:       stride = '1;
         2:       stride = STRIDE_W'($urandom_range(1, 8));
         3:       stride = STRIDE_W'($urandom_range(16, 128));
         default: stride = STRIDE_W'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0:       pitch = PITCH_W'(cols);
         1, 2:    pitch = PITCH_W'(cols) + PITCH_W'($urandom_range(1, 16));
         3:       pitch = PITCH_W'($urandom);
         4:       pitch = '1;
         default: pitch = PITCH_W'($urandom_range(0, 3));   // often below the width
      endcase
      load_setup(start, stride, rows, cols, pitch);
   endtask

   // mostly plain advances so whole tiles get walked; halfway through the
   // sender waits until nothing is outstanding
   task automatic run_items(input int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain_results();
         send_request($urandom_range(0, 99) < RESTART_PCT);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed part, sender 19% idle, receiver 75% stalled ---

      // register defaults: 1x1 tile, every transaction ends a tile
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);

      // 2x3 tile straddling the top of the address space
      drain_results();
      load_setup(32'hFFFF_FFE0, 16'd16, 13'd2, 13'd3, 16'd3);
      repeat (6) send_request(1'b0);

      // zero stride, oversized rows (saturate), zero columns and pitch
      drain_results();
      load_setup(32'h0000_1000, 16'd0, 13'h1FFF, 13'd0, 16'd0);
      repeat (4) send_request(1'b0);

      // shrink the shape under a walk at row 4, then pitch below the width:
      // the second row revisits lines the first row already left
      drain_results();
      load_setup(32'h0000_0000, 16'd64, 13'd3, 13'd5, 16'd1);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      repeat (6) send_request(1'b0);

      // every register at its maximum
      drain_results();
      load_setup(32'hFFFF_FFFF, 16'hFFFF, 13'(MAX_DIM), 13'(MAX_DIM), 16'hFFFF);
      repeat (3) send_request(1'b0);

      // --- random part: two setups per idling pattern ---
      for (int s = 0; s < RANDOM_SETUPS; s++) begin
         if (s == 2) begin
            tx_idle_pct <= 75;
            rx_idle_pct <= 19;
         end else if (s == 4) begin
            tx_idle_pct <= 0;
            rx_idle_pct <= 0;
         end
         drain_results();
         random_setup();
         run_items(ITEMS_PER_SETUP);
      end

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Walked %0d request transactions over %0d register setups.",
               sent_count, setup_count);
      $display("Checked %0d results: %0d tiles completed, %0d new lines reported.",
               result_count, tile_count, line_count);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
